// File: src/c8x_pkg.sv
// Shared types and constants for the CHIP-8 execute slice.
package c8x_pkg;

  localparam int MEM_DEPTH_DEF = 4096;

  localparam int CMD_W  = 2;
  localparam int OPC_W  = 16;
  localparam int HADDR_W = 12;
  localparam int BYTE_W = 8;
  localparam int SEL_W  = 5;
  localparam int RDATA_W = 12;
  localparam int NREGS  = 16;

  localparam logic [CMD_W-1:0] CMD_EXEC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MEM_WR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MEM_RD = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REG_RD = 2'd3;

  localparam logic [3:0] OP_LD_IMM  = 4'h6;
  localparam logic [3:0] OP_ADD_IMM = 4'h7;
  localparam logic [3:0] OP_ALU     = 4'h8;
  localparam logic [3:0] OP_LD_I    = 4'hA;
  localparam logic [3:0] OP_MISC    = 4'hF;

  localparam logic [7:0] FN_STORE = 8'h55;
  localparam logic [7:0] FN_LOAD  = 8'h65;

  localparam logic [3:0]       FLAG_REG = 4'hF;
  localparam logic [SEL_W-1:0] SEL_I    = 5'd16;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  // Codes follow the low nibble of the 8xyN opcodes.
  typedef enum logic [2:0] {
    ALU_MOV = 3'd0,
    ALU_OR  = 3'd1,
    ALU_AND = 3'd2,
    ALU_XOR = 3'd3,
    ALU_ADD = 3'd4,
    ALU_SUB = 3'd5
  } alu_op_t;

  localparam logic [3:0] ALU_LAST_FN = 4'h5;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              flag;
  } alu_res_t;

endpackage

// File: src/c8x_if.sv
// Request and response channel interfaces.
interface c8x_req_if;
  logic                          valid;
  logic                          ready;
  logic [c8x_pkg::CMD_W-1:0]     command;
  logic [c8x_pkg::OPC_W-1:0]     opcode;
  logic [c8x_pkg::HADDR_W-1:0]   host_addr;
  logic [c8x_pkg::BYTE_W-1:0]    host_data;
  logic [c8x_pkg::SEL_W-1:0]     reg_select;

  modport source (output valid, command, opcode, host_addr, host_data, reg_select,
                  input ready);
  modport sink (input valid, command, opcode, host_addr, host_data, reg_select,
                output ready);
endinterface

interface c8x_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [c8x_pkg::RDATA_W-1:0]   read_data;
  logic                          status;

  modport source (output valid, read_data, status, input ready);
  modport sink (input valid, read_data, status, output ready);
endinterface

// File: src/c8x_ram.sv
// Generic single-port RAM with registered read.
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: src/c8x_alu.sv
// Shared 8-bit ALU for register arithmetic and logic.
module c8x_alu (
  input  c8x_pkg::alu_op_t                op,
  input  logic [c8x_pkg::BYTE_W-1:0]      a,
  input  logic [c8x_pkg::BYTE_W-1:0]      b,
  output c8x_pkg::alu_res_t               res
);

  logic [c8x_pkg::BYTE_W:0] sum;
  logic [c8x_pkg::BYTE_W:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};

  always_comb begin
    res = '0;
    unique case (op)
      c8x_pkg::ALU_MOV: res.value = b;
      c8x_pkg::ALU_OR:  res.value = a | b;
      c8x_pkg::ALU_AND: res.value = a & b;
      c8x_pkg::ALU_XOR: res.value = a ^ b;
      c8x_pkg::ALU_ADD: begin
        res.value = sum[c8x_pkg::BYTE_W-1:0];
        res.flag  = sum[c8x_pkg::BYTE_W];
      end
      c8x_pkg::ALU_SUB: begin
        res.value = diff[c8x_pkg::BYTE_W-1:0];
        res.flag  = ~diff[c8x_pkg::BYTE_W];
      end
      default: res = '0;
    endcase
  end

endmodule

// File: src/chip8_alu_load_store_execute.sv
// CHIP-8 execute slice: top level with sequencer, register file and data memory.
// Host memory accesses, Fx55 and Fx65 first fold the address into range, subtracting
// MEM_DEPTH once per step while it is too large. Fx55 stores and Fx65 loads V0..Vx
// from I onward. Bytes move one per cycle through the single RAM port.
// One request is taken at a time; a response waits in the output register.
// Reset (rst, synchronous) clears V0..VF, I and control; data memory is not cleared.
module chip8_alu_load_store_execute #(
  parameter int MEM_DEPTH = c8x_pkg::MEM_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  c8x_req_if.sink    req,
  c8x_rsp_if.source  rsp
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int RW = (AW + 1 > c8x_pkg::HADDR_W + 1) ? AW + 1 : c8x_pkg::HADDR_W + 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DEC   = 10'b0000000010,
    S_RDY   = 10'b0000000100,
    S_FLAG  = 10'b0000001000,
    S_RED   = 10'b0000010000,
    S_HMEM  = 10'b0000100000,
    S_HCAP  = 10'b0001000000,
    S_STORE = 10'b0010000000,
    S_LOAD  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // Latched request
  logic [c8x_pkg::CMD_W-1:0]   cmd;
  logic [c8x_pkg::OPC_W-1:0]   op;
  logic [c8x_pkg::HADDR_W-1:0] haddr;
  logic [c8x_pkg::BYTE_W-1:0]  hdata;
  logic [c8x_pkg::SEL_W-1:0]   sel;

  logic [c8x_pkg::BYTE_W-1:0]  v [c8x_pkg::NREGS];
  logic [c8x_pkg::HADDR_W-1:0] idx;

  logic [c8x_pkg::BYTE_W-1:0]  a;
  logic                        flag;
  logic [RW-1:0]               red;
  logic [AW-1:0]               addr;
  logic [3:0]                  k;
  logic [3:0]                  wk;
  logic                        pv;

  logic [c8x_pkg::RDATA_W-1:0] rd;
  logic                        st;
  logic                        out_valid;
  logic [c8x_pkg::RDATA_W-1:0] out_rd;
  logic                        out_st;

  logic [3:0] fx, fy, fn;
  logic [7:0] kk;
  assign fx = op[11:8];
  assign fy = op[7:4];
  assign fn = op[3:0];
  assign kk = op[7:0];

  // Register file port
  logic [3:0]                 raddr;
  logic [c8x_pkg::BYTE_W-1:0] rval;
  logic                       rwe;
  logic [3:0]                 rwaddr;
  logic [c8x_pkg::BYTE_W-1:0] rwdata;

  assign rval = v[raddr];

  // ALU
  c8x_pkg::alu_op_t           alu_op;
  logic [c8x_pkg::BYTE_W-1:0] alu_a, alu_b;
  c8x_pkg::alu_res_t          alu_res;

  c8x_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // Data memory
  logic                       mem_we;
  logic [c8x_pkg::BYTE_W-1:0] mem_wdata;
  logic [c8x_pkg::BYTE_W-1:0] mem_q;

  c8x_ram #(
    .WIDTH (c8x_pkg::BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (addr),
    .wdata (mem_wdata),
    .rdata (mem_q)
  );

  logic [AW:0]   addr_plus;
  logic [AW-1:0] addr_inc;
  logic          red_big;

  assign addr_plus = {1'b0, addr} + (AW + 1)'(1);
  assign addr_inc  = (addr_plus == (AW + 1)'(MEM_DEPTH)) ? '0 : addr_plus[AW-1:0];
  assign red_big   = (red >= RW'(MEM_DEPTH));

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_rd;
  assign rsp.status    = out_st;

  always_comb begin
    raddr     = fx;
    rwe       = 1'b0;
    rwaddr    = fx;
    rwdata    = alu_res.value;
    alu_op    = c8x_pkg::ALU_ADD;
    alu_a     = rval;
    alu_b     = kk;
    mem_we    = 1'b0;
    mem_wdata = hdata;
    unique case (state)
      S_DEC: begin
        if (cmd == c8x_pkg::CMD_REG_RD) begin
          raddr = sel[3:0];
        end else if (op[15:12] == c8x_pkg::OP_LD_IMM) begin
          rwe    = (cmd == c8x_pkg::CMD_EXEC);
          rwdata = kk;
        end else if (op[15:12] == c8x_pkg::OP_ADD_IMM) begin
          rwe = (cmd == c8x_pkg::CMD_EXEC);
        end
      end
      S_RDY: begin
        raddr  = fy;
        alu_op = c8x_pkg::alu_op_t'(fn[2:0]);
        alu_a  = a;
        alu_b  = rval;
        rwe    = 1'b1;
      end
      S_FLAG: begin
        rwe    = 1'b1;
        rwaddr = c8x_pkg::FLAG_REG;
        rwdata = {{(c8x_pkg::BYTE_W-1){1'b0}}, flag};
      end
      S_HMEM: begin
        mem_we = (cmd == c8x_pkg::CMD_MEM_WR);
      end
      S_STORE: begin
        raddr     = k;
        mem_we    = 1'b1;
        mem_wdata = rval;
      end
      S_LOAD: begin
        rwe    = pv;
        rwaddr = wk;
        rwdata = mem_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req.valid) state_next = S_DEC;
      S_DEC: begin
        if (cmd == c8x_pkg::CMD_MEM_WR || cmd == c8x_pkg::CMD_MEM_RD) begin
          state_next = S_RED;
        end else if (cmd == c8x_pkg::CMD_REG_RD) begin
          state_next = S_DONE;
        end else if (op[15:12] == c8x_pkg::OP_ALU && fn <= c8x_pkg::ALU_LAST_FN) begin
          state_next = S_RDY;
        end else if (op[15:12] == c8x_pkg::OP_MISC &&
                     (kk == c8x_pkg::FN_STORE || kk == c8x_pkg::FN_LOAD)) begin
          state_next = S_RED;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RDY: begin
        if (fn == 4'(c8x_pkg::ALU_ADD) || fn == 4'(c8x_pkg::ALU_SUB)) begin
          state_next = S_FLAG;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FLAG: state_next = S_DONE;
      S_RED: begin
        if (!red_big) begin
          if (cmd != c8x_pkg::CMD_EXEC) begin
            state_next = S_HMEM;
          end else if (kk == c8x_pkg::FN_STORE) begin
            state_next = S_STORE;
          end else begin
            state_next = S_LOAD;
          end
        end
      end
      S_HMEM:  state_next = (cmd == c8x_pkg::CMD_MEM_WR) ? S_DONE : S_HCAP;
      S_HCAP:  state_next = S_DONE;
      S_STORE: if (k == fx) state_next = S_DONE;
      S_LOAD:  if (pv && wk == fx) state_next = S_DONE;
      S_DONE:  if (!out_valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
      pv        <= 1'b0;
      for (int i = 0; i < c8x_pkg::NREGS; i++) begin
        v[i] <= '0;
      end
    end else begin
      state <= state_next;
      pv    <= (state == S_LOAD);
      if (rwe) begin
        v[rwaddr] <= rwdata;
      end
      if (state == S_DEC && cmd == c8x_pkg::CMD_EXEC && op[15:12] == c8x_pkg::OP_LD_I) begin
        idx <= op[11:0];
      end
      if (state == S_DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    wk <= k;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          cmd   <= req.command;
          op    <= req.opcode;
          haddr <= req.host_addr;
          hdata <= req.host_data;
          sel   <= req.reg_select;
        end
      end
      S_DEC: begin
        a   <= rval;
        k   <= '0;
        rd  <= '0;
        st  <= c8x_pkg::STATUS_OK;
        red <= (cmd == c8x_pkg::CMD_EXEC) ? RW'(idx) : RW'(haddr);
        if (cmd == c8x_pkg::CMD_REG_RD) begin
          if (sel < c8x_pkg::SEL_I) begin
            rd <= c8x_pkg::RDATA_W'(rval);
          end else if (sel == c8x_pkg::SEL_I) begin
            rd <= idx;
          end
        end else if (cmd == c8x_pkg::CMD_EXEC) begin
          priority if (op[15:12] == c8x_pkg::OP_LD_IMM || op[15:12] == c8x_pkg::OP_ADD_IMM ||
                       op[15:12] == c8x_pkg::OP_LD_I) begin
            st <= c8x_pkg::STATUS_OK;
          end else if (op[15:12] == c8x_pkg::OP_ALU) begin
            st <= (fn <= c8x_pkg::ALU_LAST_FN) ? c8x_pkg::STATUS_OK : c8x_pkg::STATUS_IGNORED;
          end else if (op[15:12] == c8x_pkg::OP_MISC) begin
            st <= (kk == c8x_pkg::FN_STORE || kk == c8x_pkg::FN_LOAD) ?
                  c8x_pkg::STATUS_OK : c8x_pkg::STATUS_IGNORED;
          end else begin
            st <= c8x_pkg::STATUS_IGNORED;
          end
        end
      end
      S_RDY: flag <= alu_res.flag;
      S_RED: begin
        // Fold the address into range one subtraction at a time
        if (red_big) begin
          red <= red - RW'(MEM_DEPTH);
        end else begin
          addr <= red[AW-1:0];
        end
      end
      S_HCAP: rd <= c8x_pkg::RDATA_W'(mem_q);
      S_STORE: begin
        k    <= k + 4'd1;
        addr <= addr_inc;
      end
      S_LOAD: begin
        k    <= k + 4'd1;
        addr <= addr_inc;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_rd <= rd;
          out_st <= st;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
